// File: sv/dq_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies; imported by the controller, the datapath and the top level.
package dq_pkg;

    // Access codes carried in the input tuser field
    localparam logic [1:0] FUNC_PUSH     = 2'd0;
    localparam logic [1:0] FUNC_GET_HEAD = 2'd1;
    localparam logic [1:0] FUNC_POP_TAIL = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIN
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;   // capture the accepted item
        logic exec;      // apply the access to pointers, count and RAM
        logic load_out;  // move the finished result into the output register
    } ctrl_cmd_t;

endpackage

// File: sv/dq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; instanced by the datapath for entry storage.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/dq_ctrl.sv
// Controller state machine for the double-ended queue: input/output handshakes
// and sequencing of the datapath. Depends on dq_pkg.
module dq_ctrl
    import dq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    // State and output-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // read data is ready here; wait for a free output register
                if (!out_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register occupancy
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

// File: sv/dq_datapath.sv
// Datapath of the double-ended queue: pointers, entry count, entry RAM and
// result registers. Depends on dq_pkg and dq_ram.
module dq_datapath
    import dq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  ctrl_cmd_t   cmd,
    input  logic [1:0]  in_func,
    input  logic [31:0] in_value,
    output logic [31:0] out_value,
    output logic        out_empty,
    output logic        out_over,
    output logic [4:0]  out_occ
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // Captured item
    logic [1:0]            func_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [63:0]           in_ext;

    // Queue state
    logic [AW-1:0] front_reg, front_next;
    logic [AW-1:0] back_reg, back_next;
    logic [CW-1:0] count_reg, count_next;

    // Pending result flags between the access and the output register
    logic rd_sel_reg, empty_reg, over_reg;
    logic rd_en, wr_en, empty_n, over_n;
    logic [AW-1:0] rd_addr;

    // Result register
    logic [31:0] out_value_reg;
    logic        out_empty_reg, out_over_reg;
    logic [4:0]  out_occ_reg;

    logic [DATA_WIDTH-1:0] ram_rd_data;
    logic [63:0]           rd_ext;

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
        return (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    // Input value reduced to the entry width
    assign in_ext = 64'(in_value);

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg  <= in_func;
            value_reg <= in_ext[DATA_WIDTH-1:0];
        end
    end

    // Access decode: pointer moves, count update, RAM strobes
    always_comb begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        rd_addr    = front_reg;
        empty_n    = 1'b0;
        over_n     = 1'b0;
        if (cmd.exec) begin
            case (func_reg)
                FUNC_PUSH: begin
                    // null entry is ignored
                    if (value_reg != '0) begin
                        if (count_reg == FULL_CNT) begin
                            over_n = 1'b1;
                        end else begin
                            wr_en      = 1'b1;
                            back_next  = idx_inc(back_reg);
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                FUNC_GET_HEAD: begin
                    if (count_reg == '0) begin
                        empty_n = 1'b1;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = front_reg;
                        front_next = idx_inc(front_reg);
                        count_next = count_reg - 1'b1;
                    end
                end
                FUNC_POP_TAIL: begin
                    if (count_reg == '0) begin
                        empty_n = 1'b1;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = idx_dec(back_reg);
                        back_next  = idx_dec(back_reg);
                        count_next = count_reg - 1'b1;
                    end
                end
                default: begin
                    // unused code: no effect
                end
            endcase
        end
    end

    // Queue state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end else begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

    // Pending flags
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            rd_sel_reg <= rd_en;
            empty_reg  <= empty_n;
            over_reg   <= over_n;
        end
    end

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (back_reg),
        .wr_data (value_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_ext = 64'(ram_rd_data);

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_value_reg <= rd_sel_reg ? rd_ext[31:0] : 32'd0;
            out_empty_reg <= empty_reg;
            out_over_reg  <= over_reg;
            out_occ_reg   <= 5'(count_reg);
        end
    end

    assign out_value = out_value_reg;
    assign out_empty = out_empty_reg;
    assign out_over  = out_over_reg;
    assign out_occ   = out_occ_reg;

endmodule

// File: sv/double_ended_queue_top.sv
// Top level of the double-ended queue: stream ports, controller and datapath.
// Depends on dq_pkg, dq_ctrl, dq_datapath (and through it dq_ram).
//
//   channel  | dir | tdata                             | tuser
//   s_axis   | in  | [31:0] value                      | [1:0] func
//   m_axis   | out | [31:0] out_value, [36:32] occupancy | [0] was_empty, [1] overflow
//
// After an item is accepted, its result becomes valid through the access step
// (pointer update with RAM write or registered RAM read), then the output register load.
// One item is in work at a time (accept, access, load): a new item is accepted
// only after the last one's result has been loaded into the output register.
// A finished result waits in the output register; the next item may be accepted
// meanwhile, and it stalls only when its own result finds that register full.
// Synchronous active-low reset empties the queue; stored entries are not cleared.
module double_ended_queue_top
    import dq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] out_value, [36:32] occupancy
    output logic [1:0]  m_axis_tuser    // [0] was_empty, [1] overflow
);

    ctrl_cmd_t   cmd;
    logic [31:0] out_value;
    logic        out_empty;
    logic        out_over;
    logic [4:0]  out_occ;

    dq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd)
    );

    dq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_func   (s_axis_tuser),
        .in_value  (s_axis_tdata),
        .out_value (out_value),
        .out_empty (out_empty),
        .out_over  (out_over),
        .out_occ   (out_occ)
    );

    // Result packing
    assign m_axis_tdata = {3'b000, out_occ, out_value};
    assign m_axis_tuser = {out_over, out_empty};

endmodule

// File: sv/dq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
// No package dependency; sees only the top-level ports.
module dq_checker #(
    parameter int DEPTH = 16
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A stalled result holds its contents
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // An empty removal returns no entry, and never together with overflow
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[31:0] == 32'd0 && !m_axis_tuser[1])
        else $error("empty removal returned data or overflow");

    // A dropped push reports a full queue
    a_over: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tdata[36:32] == 5'(DEPTH) && m_axis_tdata[31:0] == 32'd0)
        else $error("overflow without full occupancy");

    // One item in work at a time: no acceptance right after an acceptance
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready while an item is in work");

    // Reset leaves no result pending
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind double_ended_queue_top dq_checker #(.DEPTH(DEPTH)) u_dq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
